// ===== rtl/facewise_tensor_product_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Facewise tensor product unit assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FACEWISE_TENSOR_PRODUCT_UNIT_MACROS_SVH
`define FACEWISE_TENSOR_PRODUCT_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define FWTP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FWTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FWTP_ASSERT_SAME(lbl, ante, cons, msg)
`define FWTP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/fwtp_pkg.sv =====
// ----------------------------------------------------------------------------
// Facewise tensor product package
// Sizes, field widths, codes and helpers shared by the unit and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package fwtp_pkg;

  localparam int MAX_ROWS   = 16;
  localparam int MAX_INNER  = 16;
  localparam int MAX_COLS   = 16;
  localparam int MAX_SLICES = 16;

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 4;
  localparam int VAL_W     = 16;
  localparam int MUL_W     = 2 * VAL_W;
  localparam int PROD_W    = 40;
  localparam int FUNC_W    = 2;
  localparam int IN_DATA_W = 32;
  localparam int CNT_W     = 7;

  localparam int DEPTH_A  = MAX_ROWS * MAX_INNER * MAX_SLICES;
  localparam int DEPTH_B  = MAX_INNER * MAX_COLS * MAX_SLICES;
  localparam int ADDR_A_W = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int ADDR_B_W = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int L_W      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(16);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A = 2'd0,
    FUNC_LOAD_B = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A      = 2'd0,
    REG_INNER_SIZE  = 2'd1,
    REG_COLS_B      = 2'd2,
    REG_SLICE_COUNT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_FLUSH,
    S_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int maxv);
    return (int'(v) > maxv) ? CNT_W'(maxv) : CNT_W'(v);
  endfunction

  function automatic logic [ADDR_A_W-1:0] addr_a(input int r, input int l, input int s);
    return ADDR_A_W'((r * MAX_INNER + l) * MAX_SLICES + s);
  endfunction

  function automatic logic [ADDR_B_W-1:0] addr_b(input int l, input int c, input int s);
    return ADDR_B_W'((l * MAX_COLS + c) * MAX_SLICES + s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fwtp_ram.sv =====
// ----------------------------------------------------------------------------
// Facewise tensor product RAM
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fwtp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/facewise_tensor_product_unit.sv =====
// ----------------------------------------------------------------------------
// Facewise tensor product unit
// Loads elements of A and B into two RAMs and answers queries for one
// element of the slice-wise product C[i][j][k] = sum_l A[i][l][k]*B[l][j][k].
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  in_     | slave     | row, col, slice, value        | func
//  out_    | master    | product                       | index_error
//  cfg_    | slave     | cfg_index selects the size register, cfg_data the value
//
// A load item is written to its RAM at the accepting edge. A query makes one
// RAM read per inner term, ni being inner_size capped at MAX_INNER, as each
// RAM has a single read port; then come the registered read, the product
// register and the final accumulate. Out-of-range queries and queries with
// an inner size of zero skip the reads and go straight to the result.
// rst_n resets control and sets the size registers to 16; RAM contents are
// undefined until loaded. A finished result waits in the output register
// while the next item is taken; a second one stalls until out_tready frees it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "facewise_tensor_product_unit_macros.svh"

module facewise_tensor_product_unit
  import fwtp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // row[3:0] col[7:4] slice[11:8] value[27:12]
  input  wire logic [FUNC_W-1:0]      in_tuser,   // func[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [PROD_W-1:0]      out_tdata,  // product[39:0]
  output logic                        out_tuser,  // index_error[0]
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_a_r, inner_size_r, cols_b_r, slice_count_r;
  logic [CNT_W-1:0] nr, ni, nc, ns;

  func_t             in_func;
  logic [IDX_W-1:0]  in_row, in_col, in_slice;
  logic [VAL_W-1:0]  in_value;
  logic              in_fire, q_ok, la_ok, lb_ok;

  logic [IDX_W-1:0]  row_r, col_r, slice_r;
  logic [L_W-1:0]    l_r;
  logic              rd_vld_r, rd_last_r, mul_vld_r, mul_last_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic signed [PROD_W-1:0] acc_r;
  logic              err_r;
  logic              out_tvalid_r, out_err_r;
  logic [PROD_W-1:0] out_product_r;

  logic              issue, issue_last, out_free, res_load;

  logic                ram_a_we, ram_b_we;
  logic [ADDR_A_W-1:0] ram_a_waddr, ram_a_raddr;
  logic [ADDR_B_W-1:0] ram_b_waddr, ram_b_raddr;
  logic signed [VAL_W-1:0] ram_a_rdata, ram_b_rdata;

  // decode the input item
  assign in_func  = func_t'(in_tuser);
  assign in_row   = in_tdata[IDX_W-1:0];
  assign in_col   = in_tdata[2*IDX_W-1:IDX_W];
  assign in_slice = in_tdata[3*IDX_W-1:2*IDX_W];
  assign in_value = in_tdata[3*IDX_W+VAL_W-1:3*IDX_W];

  assign nr = clamp_size(rows_a_r, MAX_ROWS);
  assign ni = clamp_size(inner_size_r, MAX_INNER);
  assign nc = clamp_size(cols_b_r, MAX_COLS);
  assign ns = clamp_size(slice_count_r, MAX_SLICES);

  assign in_fire = in_tvalid && in_tready;
  assign q_ok  = (CNT_W'(in_row) < nr) && (CNT_W'(in_col) < nc) && (CNT_W'(in_slice) < ns);
  assign la_ok = (CNT_W'(in_row) < nr) && (CNT_W'(in_col) < ni) && (CNT_W'(in_slice) < ns);
  assign lb_ok = (CNT_W'(in_row) < ni) && (CNT_W'(in_col) < nc) && (CNT_W'(in_slice) < ns);

  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_func == FUNC_QUERY) begin
          state_nxt = (q_ok && ni != '0) ? S_ISSUE : S_DONE;
        end
      end
      S_ISSUE: begin
        if (issue_last) begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (mul_vld_r && mul_last_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    issue      = 1'b0;
    res_load   = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_ISSUE: issue     = 1'b1;
      S_FLUSH: ;
      S_DONE:  res_load  = out_free;
      default: ;
    endcase
  end

  assign issue_last = issue && ((CNT_W'(l_r) + CNT_W'(1)) == ni);

  // RAM ports
  assign ram_a_we    = in_fire && in_func == FUNC_LOAD_A && la_ok;
  assign ram_b_we    = in_fire && in_func == FUNC_LOAD_B && lb_ok;
  assign ram_a_waddr = addr_a(int'(in_row), int'(in_col), int'(in_slice));
  assign ram_b_waddr = addr_b(int'(in_row), int'(in_col), int'(in_slice));
  assign ram_a_raddr = addr_a(int'(row_r), int'(l_r), int'(slice_r));
  assign ram_b_raddr = addr_b(int'(l_r), int'(col_r), int'(slice_r));

  fwtp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_A)) u_ram_a (
    .clk   (clk),
    .we    (ram_a_we),
    .waddr (ram_a_waddr),
    .wdata (in_value),
    .raddr (ram_a_raddr),
    .rdata (ram_a_rdata)
  );

  fwtp_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH_B)) u_ram_b (
    .clk   (clk),
    .we    (ram_b_we),
    .waddr (ram_b_waddr),
    .wdata (in_value),
    .raddr (ram_b_raddr),
    .rdata (ram_b_rdata)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_a_r      <= SIZE_RESET;
      inner_size_r  <= SIZE_RESET;
      cols_b_r      <= SIZE_RESET;
      slice_count_r <= SIZE_RESET;
      rd_vld_r      <= 1'b0;
      mul_vld_r     <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= issue;
      mul_vld_r <= rd_vld_r;
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ROWS_A:      rows_a_r      <= cfg_data;
          REG_INNER_SIZE:  inner_size_r  <= cfg_data;
          REG_COLS_B:      cols_b_r      <= cfg_data;
          REG_SLICE_COUNT: slice_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (res_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rd_last_r  <= issue_last;
    mul_last_r <= rd_last_r;
    mul_r      <= ram_a_rdata * ram_b_rdata;
    if (in_fire && in_func == FUNC_QUERY) begin
      row_r   <= in_row;
      col_r   <= in_col;
      slice_r <= in_slice;
      l_r     <= '0;
      acc_r   <= '0;
      err_r   <= !q_ok;
    end else begin
      if (issue) begin
        l_r <= l_r + L_W'(1);
      end
      if (mul_vld_r) begin
        acc_r <= acc_r + PROD_W'(mul_r);
      end
    end
    if (res_load) begin
      out_product_r <= acc_r;
      out_err_r     <= err_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_product_r;
  assign out_tuser  = out_err_r;

  `FWTP_ASSERT_SAME(a_issue_in_range, state_r == S_ISSUE, CNT_W'(l_r) < ni, "inner index past size")
  `FWTP_ASSERT_NEXT(a_pipe_advance, rd_vld_r, mul_vld_r, "read data not multiplied")
  `FWTP_ASSERT_NEXT(a_result_shown, res_load, out_tvalid_r && state_r == S_IDLE, "result not loaded")
  `FWTP_ASSERT_SAME(a_error_zero, out_tvalid_r && out_err_r, out_product_r == '0, "error with nonzero product")

endmodule

`default_nettype wire

// ===== test/tb_facewise_tensor_product_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Facewise tensor product unit testbench
// Loads elements of A and B, queries elements of the slice-wise product and
// checks every result against a local model of the stores and size
// registers. The run goes through several size settings, among them zero,
// one, full and saturating sizes. Each setting is run with one of four
// patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

module tb_facewise_tensor_product_unit;
  import fwtp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 100;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  slice;
    logic [VAL_W-1:0]  value;
  } tensor_op_t;

  typedef struct {
    logic [PROD_W-1:0] product;
    logic              index_error;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  slice;
  } c_elem_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  wire                  in_tready;
  logic [IN_DATA_W-1:0] in_tdata   = '0;
  logic [FUNC_W-1:0]    in_tuser   = '0;
  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  wire  [PROD_W-1:0]    out_tdata;
  wire                  out_tuser;
  logic                 cfg_valid  = 1'b0;
  wire                  cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  facewise_tensor_product_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // model state
  logic [VAL_W-1:0] a_elems [DEPTH_A];
  logic [VAL_W-1:0] b_elems [DEPTH_B];
  logic [CFG_W-1:0] size_reg [4] = '{SIZE_RESET, SIZE_RESET, SIZE_RESET, SIZE_RESET};

  // stimulus state
  bit         a_written [DEPTH_A];
  bit         b_written [DEPTH_B];
  int         plan_nr = 16, plan_ni = 16, plan_nc = 16, plan_ns = 16;
  int         phase_work;
  tensor_op_t tensor_ops_q [$];
  c_elem_t    c_expected_q [$];
  tensor_op_t held_op;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  in_taken = 1'b0;
  int  n_issued = 0, n_accepted = 0, n_cfg = 0;
  int  n_loads = 0, n_queries = 0, n_index_err = 0, n_checked = 0;
  int  n_fail = 0;
  int  cycles_run = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int eff_size(logic [CFG_W-1:0] v, int maxv);
    return (int'(v) > maxv) ? maxv : int'(v);
  endfunction

  task automatic apply_op(input tensor_op_t op);
    int      nr, ni, nc, ns;
    longint  acc;
    c_elem_t res;
    nr = eff_size(size_reg[REG_ROWS_A], MAX_ROWS);
    ni = eff_size(size_reg[REG_INNER_SIZE], MAX_INNER);
    nc = eff_size(size_reg[REG_COLS_B], MAX_COLS);
    ns = eff_size(size_reg[REG_SLICE_COUNT], MAX_SLICES);
    case (op.func)
      FUNC_LOAD_A: begin
        n_loads++;
        if (op.row < nr && op.col < ni && op.slice < ns)
          a_elems[{op.row, op.col, op.slice}] = op.value;
      end
      FUNC_LOAD_B: begin
        n_loads++;
        if (op.row < ni && op.col < nc && op.slice < ns)
          b_elems[{op.row, op.col, op.slice}] = op.value;
      end
      FUNC_QUERY: begin
        n_queries++;
        res.row = op.row;
        res.col = op.col;
        res.slice = op.slice;
        if (!(op.row < nr && op.col < nc && op.slice < ns)) begin
          res.product = '0;
          res.index_error = 1'b1;
          n_index_err++;
        end else begin
          acc = 0;
          for (int l = 0; l < ni; l++)
            acc += longint'($signed(a_elems[{op.row, IDX_W'(l), op.slice}])) *
                   longint'($signed(b_elems[{IDX_W'(l), op.col, op.slice}]));
          res.product = acc[PROD_W-1:0];
          res.index_error = 1'b0;
        end
        c_expected_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // accept, predict and check
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n && cfg_valid && cfg_ready) begin
      size_reg[cfg_index] = cfg_data;
      n_cfg++;
    end
    if (in_taken) begin
      apply_op(held_op);
      n_accepted++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (c_expected_q.size() == 0) begin
        $display("%0t: unexpected result: actual product %0d index_error %0b",
                 $realtime, $signed(out_tdata), out_tuser);
        n_fail++;
      end else begin
        c_elem_t want;
        want = c_expected_q.pop_front();
        n_checked++;
        if (out_tdata !== want.product || out_tuser !== want.index_error) begin
          $display("%0t: mismatch at C(%0d,%0d,%0d): expected product %0d index_error %0b,",
                   $realtime, want.row, want.col, want.slice, $signed(want.product),
                   want.index_error);
          $display("    actual product %0d index_error %0b", $signed(out_tdata), out_tuser);
          n_fail++;
        end
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (tensor_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        held_op = tensor_ops_q.pop_front();
        in_tdata <= {4'b0, held_op.value, held_op.slice, held_op.col, held_op.row};
        in_tuser <= held_op.func;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("%0t: timeout with %0d results outstanding", $realtime, c_expected_q.size());
    $display("FAILURE");
    $finish;
  end

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] v);
    int seen;
    seen = n_cfg;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    while (n_cfg == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] i,
                           input logic [CFG_W-1:0] c, input logic [CFG_W-1:0] s);
    cfg_write(REG_ROWS_A, r);
    cfg_write(REG_INNER_SIZE, i);
    cfg_write(REG_COLS_B, c);
    cfg_write(REG_SLICE_COUNT, s);
    plan_nr = eff_size(r, MAX_ROWS);
    plan_ni = eff_size(i, MAX_INNER);
    plan_nc = eff_size(c, MAX_COLS);
    plan_ns = eff_size(s, MAX_SLICES);
  endtask

  task automatic wait_idle();
    while (tensor_ops_q.size() != 0 || n_accepted != n_issued || c_expected_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      default: begin send_idle_pct = 28; recv_stall_pct = 28; end
    endcase
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  function automatic int pick(input int n);
    return (n > 0) ? $urandom_range(n - 1, 0) : $urandom_range(15, 0);
  endfunction

  task automatic push_op(input logic [FUNC_W-1:0] f, input int r, input int c, input int s,
                         input logic [VAL_W-1:0] v);
    tensor_op_t op;
    op.func = f;
    op.row = IDX_W'(r);
    op.col = IDX_W'(c);
    op.slice = IDX_W'(s);
    op.value = v;
    tensor_ops_q.push_back(op);
    n_issued++;
    if (f == FUNC_QUERY) begin
      phase_work++;
    end else if (f == FUNC_LOAD_A && r < plan_nr && c < plan_ni && s < plan_ns) begin
      a_written[{op.row, op.col, op.slice}] = 1'b1;
      phase_work++;
    end else if (f == FUNC_LOAD_B && r < plan_ni && c < plan_nc && s < plan_ns) begin
      b_written[{op.row, op.col, op.slice}] = 1'b1;
      phase_work++;
    end
  endtask

  // fill any unwritten operand of an in-range query first
  task automatic query_at(input int r, input int c, input int s);
    if (r < plan_nr && c < plan_nc && s < plan_ns) begin
      for (int l = 0; l < plan_ni; l++) begin
        if (!a_written[{IDX_W'(r), IDX_W'(l), IDX_W'(s)}])
          push_op(FUNC_LOAD_A, r, l, s, rand_value());
        if (!b_written[{IDX_W'(l), IDX_W'(c), IDX_W'(s)}])
          push_op(FUNC_LOAD_B, l, c, s, rand_value());
      end
    end
    push_op(FUNC_QUERY, r, c, s, VAL_W'($urandom));
  endtask

  task automatic random_phase(input int budget);
    int roll;
    phase_work = 0;
    while (phase_work < budget) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        query_at(pick(plan_nr), pick(plan_nc), pick(plan_ns));
      end else if (roll < 72) begin
        if ($urandom_range(1))
          push_op(FUNC_LOAD_A, pick(plan_nr), pick(plan_ni), pick(plan_ns), rand_value());
        else
          push_op(FUNC_LOAD_B, pick(plan_ni), pick(plan_nc), pick(plan_ns), rand_value());
      end else if (roll < 84) begin
        query_at($urandom_range(15), $urandom_range(15), $urandom_range(15));
      end else if (roll < 95) begin
        push_op($urandom_range(1) ? FUNC_LOAD_B : FUNC_LOAD_A, $urandom_range(15),
                $urandom_range(15), $urandom_range(15), rand_value());
      end else begin
        push_op(FUNC_UNUSED, $urandom_range(15), $urandom_range(15), $urandom_range(15),
                VAL_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] sz [4];
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, ignored loads, out-of-range query, unused code
    set_idle(0);
    set_sizes(5'd16, 5'd2, 5'd15, 5'd16);
    push_op(FUNC_LOAD_A, 15, 0, 15, 16'h8000);
    push_op(FUNC_LOAD_A, 15, 1, 15, 16'h8000);
    push_op(FUNC_LOAD_B, 0, 14, 15, 16'h8000);
    push_op(FUNC_LOAD_B, 1, 14, 15, 16'h8000);
    push_op(FUNC_QUERY, 15, 14, 15, 16'h0000);
    push_op(FUNC_LOAD_A, 0, 0, 0, 16'h7fff);
    push_op(FUNC_LOAD_A, 0, 1, 0, 16'h8000);
    push_op(FUNC_LOAD_B, 0, 0, 0, 16'h7fff);
    push_op(FUNC_LOAD_B, 1, 0, 0, 16'h7fff);
    push_op(FUNC_QUERY, 0, 0, 0, 16'hffff);
    push_op(FUNC_LOAD_A, 0, 2, 0, 16'h0005);
    push_op(FUNC_LOAD_B, 0, 15, 0, 16'h0007);
    push_op(FUNC_LOAD_B, 2, 0, 0, 16'h0009);
    push_op(FUNC_QUERY, 0, 15, 0, 16'h0000);
    push_op(FUNC_UNUSED, 15, 15, 15, 16'hffff);
    push_op(FUNC_QUERY, 0, 0, 0, 16'h0000);
    push_op(FUNC_LOAD_A, 15, 0, 15, 16'h7fff);
    push_op(FUNC_QUERY, 15, 14, 15, 16'h0000);
    wait_idle();

    for (int ph = 1; ph <= 12; ph++) begin
      set_idle(ph % 4);
      case (ph)
        1:  sz = '{5'd4, 5'd3, 5'd5, 5'd2};
        2:  sz = '{5'd1, 5'd1, 5'd1, 5'd1};
        3:  sz = '{5'd16, 5'd16, 5'd16, 5'd16};
        4:  sz = '{5'd31, 5'd31, 5'd31, 5'd31};
        5:  sz = '{5'd0, 5'd4, 5'd4, 5'd4};
        6:  sz = '{5'd5, 5'd0, 5'd6, 5'd3};
        7:  sz = '{5'd6, 5'd5, 5'd0, 5'd4};
        8:  sz = '{5'd7, 5'd6, 5'd5, 5'd0};
        9:  sz = '{5'd17, 5'd8, 5'd20, 5'd9};
        default: begin
          for (int k = 0; k < 4; k++)
            sz[k] = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(31))
                                             : CFG_W'($urandom_range(8, 1));
        end
      endcase
      set_sizes(sz[0], sz[1], sz[2], sz[3]);
      if (ph == 1) begin
        random_phase(PHASE_ITEMS / 2);
        wait_idle();
        random_phase(PHASE_ITEMS / 2);
      end else begin
        random_phase(PHASE_ITEMS);
      end
      wait_idle();
    end

    $display("Ran %0d loads and %0d queries (%0d out of range) over %0d size writes;",
             n_loads, n_queries, n_index_err, n_cfg);
    $display("%0d results checked in %0d cycles, %0d mismatches.", n_checked, cycles_run, n_fail);
    if (n_fail == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
